// ----- src/ftwa_pkg.sv -----
// ----------------------------------------------------------------------------
// ftwa_pkg
// Types and constants for the flow table with idle-timeout ageing.
// ----------------------------------------------------------------------------
package ftwa_pkg;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_LOOKUP = 3'd1,
    OP_TOUCH  = 3'd2,
    OP_REMOVE = 3'd3,
    OP_TICK   = 3'd4
  } ftwa_op_e;

  typedef enum logic [2:0] {
    CMD_ADD,
    CMD_LOOKUP,
    CMD_TOUCH,
    CMD_REMOVE,
    CMD_TICK,
    CMD_NOP
  } ftwa_cmd_e;

  typedef enum logic [1:0] {
    ST_HIT  = 2'd0,
    ST_NEW  = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } ftwa_status_e;

  typedef enum logic [1:0] {
    REG_IDLE_TIMEOUT = 2'd0,
    REG_CHECK_INTVL  = 2'd1,
    REG_ENCAP_CODE   = 2'd2
  } ftwa_reg_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SWEEP,
    S_STAMP,
    S_DONE
  } ftwa_state_e;

  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd30;
  localparam logic [7:0]  CHECK_INTVL_RST  = 8'd5;
  localparam logic [7:0]  ENCAP_CODE_RST   = 8'd1;
  localparam logic [1:0]  MARK_ENCAP       = 2'd3;
  localparam logic [1:0]  MARK_REFRESH     = 2'd1;
  localparam logic [6:0]  FREED_MAX        = 7'd127;

  typedef struct packed {
    logic [2:0]  operation;
    logic [3:0]  ip_ver;
    logic [31:0] remote_addr;
    logic [31:0] local_addr;
    logic [7:0]  transport_proto;
    logic [15:0] rem_port;
    logic [15:0] loc_port;
    logic [7:0]  owner_id;
    logic [31:0] remap_addr;
    logic [15:0] egress_policy;
    logic [15:0] ingress_policy;
  } ftwa_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [7:0]  entry_owner;
    logic [31:0] entry_remap;
    logic [15:0] entry_egress;
    logic [15:0] entry_ingress;
    logic [1:0]  refresh_mark;
    logic [6:0]  freed_count;
  } ftwa_out_t;

  typedef struct packed {
    logic [15:0] idle_timeout;
    logic [7:0]  check_interval;
    logic [7:0]  encap_action_code;
  } ftwa_cfg_t;

  typedef struct packed {
    ftwa_cmd_e   kind;
    logic [63:0] addrs;
    logic [43:0] rest;
    logic [7:0]  owner;
    logic [31:0] remap;
    logic [31:0] pol;
  } ftwa_cmd_t;

  typedef struct packed {
    logic      valid;
    ftwa_cmd_t cmd;
  } ftwa_q_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] addrs;
    logic [43:0] rest;
    logic [7:0]  owner;
    logic [31:0] remap;
    logic [31:0] pol;
    logic [1:0]  refresh;
    logic [31:0] seen;
  } ftwa_row_t;

  function automatic ftwa_out_t ftwa_report(ftwa_status_e st, logic [5:0] slot,
                                            ftwa_row_t row, logic [6:0] freed);
    ftwa_out_t r;
    r.status        = st;
    r.slot          = slot;
    r.entry_owner   = row.owner;
    r.entry_remap   = row.remap;
    r.entry_egress  = row.pol[31:16];
    r.entry_ingress = row.pol[15:0];
    r.refresh_mark  = row.refresh;
    r.freed_count   = freed;
    return r;
  endfunction

endpackage

// ----- src/ftwa_ram.sv -----
// ----------------------------------------------------------------------------
// ftwa_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ftwa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/ftwa_front.sv -----
// ----------------------------------------------------------------------------
// ftwa_front
// Command intake: decode the operation, pack the flow key, queue two deep.
// ----------------------------------------------------------------------------
module ftwa_front import ftwa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  ftwa_in_t in_i,
  input  logic     clearing_i,
  input  logic     pop_i,
  output logic     busy_o,
  output ftwa_q_t  head_o
);

  ftwa_cmd_t  q_q [2];
  logic       wp_q, wp_d;
  logic       rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;
  ftwa_cmd_t  cmd;

  always_comb begin
    case (ftwa_op_e'(in_i.operation))
      OP_ADD:    cmd.kind = CMD_ADD;
      OP_LOOKUP: cmd.kind = CMD_LOOKUP;
      OP_TOUCH:  cmd.kind = CMD_TOUCH;
      OP_REMOVE: cmd.kind = CMD_REMOVE;
      OP_TICK:   cmd.kind = CMD_TICK;
      default:   cmd.kind = CMD_NOP;
    endcase
    cmd.addrs = {in_i.remote_addr, in_i.local_addr};
    cmd.rest  = {in_i.ip_ver, in_i.transport_proto, in_i.rem_port, in_i.loc_port};
    cmd.owner = in_i.owner_id;
    cmd.remap = in_i.remap_addr;
    cmd.pol   = {in_i.egress_policy, in_i.ingress_policy};
  end

  assign busy_o = (cnt_q == 2'd2) || clearing_i;
  assign push   = start_i && !busy_o;
  assign pop    = pop_i && (cnt_q != 2'd0);

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.cmd   = q_q[rp_q];

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wp_q] <= cmd;
    end
  end

endmodule

// ----- src/ftwa_back.sv -----
// ----------------------------------------------------------------------------
// ftwa_back
// Command execution: table scan, insert, remove, ageing sweep and report.
// ----------------------------------------------------------------------------
module ftwa_back import ftwa_pkg::*; #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ftwa_cfg_t cfg_i,
  input  ftwa_q_t   head_i,
  output logic      pop_o,
  output logic      clearing_o,
  output logic      done_o,
  output ftwa_out_t res_o
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);
  localparam int RW = $bits(ftwa_row_t);

  ftwa_state_e state_q, state_d;
  ftwa_cmd_t   cmd_q, cmd_d;
  logic [IW-1:0] idx_q, idx_d;
  logic        iss_done_q, iss_done_d;
  logic        rd_vld_q, rd_vld_d;
  logic [IW-1:0] rd_idx_q, rd_idx_d;
  logic        hit_q, hit_d;
  logic [IW-1:0] hit_idx_q, hit_idx_d;
  ftwa_row_t   hit_row_q, hit_row_d;
  logic        free_q, free_d;
  logic [IW-1:0] free_idx_q, free_idx_d;
  logic [31:0] now_q, now_d;
  logic [31:0] last_q, last_d;
  logic        started_q, started_d;
  logic [6:0]  freed_q, freed_d;
  ftwa_out_t   res_q, res_d;

  logic          we;
  logic [IW-1:0] waddr;
  ftwa_row_t     wrow;
  logic [IW-1:0] raddr;
  logic [RW-1:0] rdata;
  ftwa_row_t     rrow;
  logic          key_eq;
  logic [31:0]   elapsed;
  logic [16:0]   lead;
  logic          near;
  logic          expire;
  logic [31:0]   last_eff;
  logic [31:0]   hit_slot32;
  logic [31:0]   free_slot32;
  ftwa_row_t     new_row;
  ftwa_row_t     upd_row;

  ftwa_ram #(.WIDTH(RW), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wrow),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rrow        = ftwa_row_t'(rdata);
  assign key_eq      = (rrow.addrs == cmd_q.addrs) && (rrow.rest == cmd_q.rest);
  assign elapsed     = now_q - rrow.seen;
  assign lead        = {1'b0, cfg_i.idle_timeout} - {9'b0, cfg_i.check_interval};
  assign near        = lead[16] || (elapsed > {16'b0, lead[15:0]});
  assign expire      = (rd_idx_q != hit_idx_q) && (elapsed > {16'b0, cfg_i.idle_timeout});
  assign last_eff    = started_q ? last_q : now_q;
  assign hit_slot32  = 32'(hit_idx_q);
  assign free_slot32 = 32'(free_idx_q);

  assign pop_o      = (state_q == S_IDLE) && head_i.valid;
  assign clearing_o = (state_q == S_CLEAR);
  assign done_o     = (state_q == S_DONE);
  assign res_o      = res_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:  if (idx_q == LAST) state_d = S_IDLE;
      S_IDLE: begin
        if (head_i.valid) begin
          if (head_i.cmd.kind == CMD_TICK || head_i.cmd.kind == CMD_NOP) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN:   if (rd_vld_q && rd_idx_q == LAST) state_d = S_DECIDE;
      S_DECIDE: begin
        if (cmd_q.kind == CMD_TOUCH && hit_q) begin
          state_d = (now_q - last_eff > {24'b0, cfg_i.check_interval}) ? S_SWEEP : S_STAMP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SWEEP:  if (rd_vld_q && rd_idx_q == LAST) state_d = S_STAMP;
      S_STAMP:  state_d = S_DONE;
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_d      = cmd_q;
    idx_d      = idx_q;
    iss_done_d = iss_done_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = rd_idx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_row_d  = hit_row_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    now_d      = now_q;
    last_d     = last_q;
    started_d  = started_q;
    freed_d    = freed_q;
    res_d      = res_q;
    we         = 1'b0;
    waddr      = hit_idx_q;
    wrow       = hit_row_q;
    raddr      = idx_q;
    new_row    = '0;
    upd_row    = rrow;

    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = idx_q;
        wrow  = '0;
        idx_d = idx_q + 1'b1;
      end
      S_IDLE: begin
        res_d      = '0;
        idx_d      = '0;
        iss_done_d = 1'b0;
        hit_d      = 1'b0;
        free_d     = 1'b0;
        freed_d    = '0;
        if (head_i.valid) begin
          cmd_d = head_i.cmd;
          if (head_i.cmd.kind == CMD_TICK) begin
            now_d = now_q + 32'd1;
          end
        end
      end
      S_SCAN, S_SWEEP: begin
        if (!iss_done_q) begin
          rd_vld_d = 1'b1;
          rd_idx_d = idx_q;
          idx_d    = idx_q + 1'b1;
          if (idx_q == LAST) iss_done_d = 1'b1;
        end
        if (rd_vld_q && state_q == S_SCAN) begin
          if (rrow.valid && key_eq && !hit_q) begin
            hit_d     = 1'b1;
            hit_idx_d = rd_idx_q;
            hit_row_d = rrow;
          end
          if (!rrow.valid && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = rd_idx_q;
          end
        end
        if (rd_vld_q && state_q == S_SWEEP && rrow.valid) begin
          if (rrow.owner != 8'd0 && near) upd_row.refresh = MARK_REFRESH;
          if (expire) begin
            upd_row.valid = 1'b0;
            if (freed_q != FREED_MAX) freed_d = freed_q + 7'd1;
          end
          we    = 1'b1;
          waddr = rd_idx_q;
          wrow  = upd_row;
          if (rd_idx_q == hit_idx_q) hit_row_d.refresh = upd_row.refresh;
        end
      end
      S_DECIDE: begin
        idx_d      = '0;
        iss_done_d = 1'b0;
        case (cmd_q.kind)
          CMD_ADD: begin
            if (hit_q) begin
              res_d = ftwa_report(ST_HIT, hit_slot32[5:0], hit_row_q, 7'd0);
            end else if (!free_q) begin
              res_d        = '0;
              res_d.status = ST_FULL;
            end else begin
              new_row.valid   = 1'b1;
              new_row.addrs   = cmd_q.addrs;
              new_row.rest    = cmd_q.rest;
              new_row.owner   = cmd_q.owner;
              new_row.remap   = cmd_q.remap;
              new_row.pol     = cmd_q.pol;
              new_row.refresh = (cmd_q.pol[31:24] == cfg_i.encap_action_code) ?
                                MARK_ENCAP : 2'd0;
              new_row.seen    = now_q;
              we    = 1'b1;
              waddr = free_idx_q;
              wrow  = new_row;
              res_d = ftwa_report(ST_NEW, free_slot32[5:0], new_row, 7'd0);
            end
          end
          CMD_LOOKUP, CMD_REMOVE: begin
            if (hit_q) begin
              res_d = ftwa_report(ST_HIT, hit_slot32[5:0], hit_row_q, 7'd0);
              if (cmd_q.kind == CMD_REMOVE) begin
                we         = 1'b1;
                wrow       = hit_row_q;
                wrow.valid = 1'b0;
              end
            end else begin
              res_d        = '0;
              res_d.status = ST_MISS;
            end
          end
          CMD_TOUCH: begin
            if (hit_q) begin
              started_d = 1'b1;
              if (now_q - last_eff > {24'b0, cfg_i.check_interval}) begin
                last_d = now_q;
              end else begin
                last_d = last_eff;
              end
            end else begin
              res_d        = '0;
              res_d.status = ST_MISS;
            end
          end
          default: res_d = '0;
        endcase
      end
      S_STAMP: begin
        we        = 1'b1;
        wrow      = hit_row_q;
        wrow.seen = now_q;
        res_d     = ftwa_report(ST_HIT, hit_slot32[5:0], hit_row_q, freed_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      idx_q      <= '0;
      iss_done_q <= 1'b0;
      rd_vld_q   <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      now_q      <= '0;
      last_q     <= '0;
      started_q  <= 1'b0;
      freed_q    <= '0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      iss_done_q <= iss_done_d;
      rd_vld_q   <= rd_vld_d;
      hit_q      <= hit_d;
      free_q     <= free_d;
      now_q      <= now_d;
      last_q     <= last_d;
      started_q  <= started_d;
      freed_q    <= freed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    rd_idx_q   <= rd_idx_d;
    hit_idx_q  <= hit_idx_d;
    hit_row_q  <= hit_row_d;
    free_idx_q <= free_idx_d;
    res_q      <= res_d;
  end

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held for more than one cycle");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> !we)
    else $error("table written outside a command");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q != S_IDLE))
    else $error("command taken without leaving idle");

  a_sweep_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP) |-> (hit_q && cmd_q.kind == CMD_TOUCH))
    else $error("sweep without a touched entry");

endmodule

// ----- src/flow_table_with_aging.sv -----
// ----------------------------------------------------------------------------
// flow_table_with_aging
// Associative flow table keyed by the six-field flow tuple, with idle ageing.
// ----------------------------------------------------------------------------
// Every command gives exactly one result on res_o, strobed by done_o for one
// cycle; the receiver cannot stall it. Once the back end takes a command, add,
// lookup and remove scan the full table through the single read port of the
// entry RAM; a touch that hits adds a stamp step, and a touch that triggers
// the ageing sweep walks the table a second time. Tick and unused codes skip
// the scan and go straight to the result. A two-deep command queue takes new
// commands while one executes. After reset a clearing pass writes every table
// entry with busy high; register writes are taken throughout.
// ----------------------------------------------------------------------------
module flow_table_with_aging import ftwa_pkg::*; #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  ftwa_in_t    in_i,
  output logic        done_o,
  output ftwa_out_t   res_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  ftwa_cfg_t cfg_q;
  ftwa_q_t   head;
  logic      pop;
  logic      clearing;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_timeout      <= IDLE_TIMEOUT_RST;
      cfg_q.check_interval    <= CHECK_INTVL_RST;
      cfg_q.encap_action_code <= ENCAP_CODE_RST;
    end else if (cfg_we_i) begin
      case (ftwa_reg_e'(cfg_idx_i))
        REG_IDLE_TIMEOUT: cfg_q.idle_timeout      <= cfg_data_i;
        REG_CHECK_INTVL:  cfg_q.check_interval    <= cfg_data_i[7:0];
        REG_ENCAP_CODE:   cfg_q.encap_action_code <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  ftwa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .in_i       (in_i),
    .clearing_i (clearing),
    .pop_i      (pop),
    .busy_o     (busy),
    .head_o     (head)
  );

  ftwa_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .head_i     (head),
    .pop_o      (pop),
    .clearing_o (clearing),
    .done_o     (done_o),
    .res_o      (res_o)
  );

endmodule

// ----- tb/flow_table_with_aging_test.sv -----
// ----------------------------------------------------------------------------
// flow_table_with_aging_test
// Self-checking bench for the flow table with idle ageing: a scoreboard keeps
// its own copy of the table, clock and registers, predicts every result and
// compares it field by field. Directed cases, then bursty random traffic.
// ----------------------------------------------------------------------------
module flow_table_with_aging_test;
  import ftwa_pkg::*;

  localparam int NSLOT = 64;
  localparam int KEYS  = 80;

  class flow_scoreboard;
    bit          vld[NSLOT];
    logic [63:0] addrs[NSLOT];
    logic [43:0] rest[NSLOT];
    logic [7:0]  owner[NSLOT];
    logic [31:0] remap[NSLOT];
    logic [31:0] pol[NSLOT];
    logic [1:0]  mark[NSLOT];
    logic [31:0] seen[NSLOT];
    logic [31:0] now_s;
    logic [31:0] last_sweep;
    bit          started;
    logic [15:0] timeout;
    logic [7:0]  intvl;
    logic [7:0]  encap;
    ftwa_out_t   pending[$];
    int          errors;
    int          checked;
    int          freed_total;

    function new();
      for (int i = 0; i < NSLOT; i++) vld[i] = 0;
      now_s = 0; last_sweep = 0; started = 0;
      timeout = IDLE_TIMEOUT_RST; intvl = CHECK_INTVL_RST; encap = ENCAP_CODE_RST;
      errors = 0; checked = 0; freed_total = 0;
    endfunction

    function void set_reg(ftwa_reg_e idx, logic [15:0] v);
      case (idx)
        REG_IDLE_TIMEOUT: timeout = v;
        REG_CHECK_INTVL:  intvl = v[7:0];
        REG_ENCAP_CODE:   encap = v[7:0];
        default: ;
      endcase
    endfunction

    function ftwa_out_t fill(ftwa_status_e st, int s);
      ftwa_out_t r;
      r = '0;
      r.status = st;
      r.slot = s[5:0];
      r.entry_owner = owner[s];
      r.entry_remap = remap[s];
      r.entry_egress = pol[s][31:16];
      r.entry_ingress = pol[s][15:0];
      r.refresh_mark = mark[s];
      return r;
    endfunction

    function void note_input(ftwa_in_t t);
      ftwa_out_t r;
      logic [63:0] a;
      logic [43:0] k;
      int s, f;
      logic [6:0] freed;
      longint lead;
      logic [31:0] el;
      r = '0;
      a = {t.remote_addr, t.local_addr};
      k = {t.ip_ver, t.transport_proto, t.rem_port, t.loc_port};
      s = -1;
      for (int i = 0; i < NSLOT; i++)
        if (s < 0 && vld[i] && addrs[i] == a && rest[i] == k) s = i;
      if (t.operation == OP_TICK) begin
        now_s = now_s + 1;
      end else if (t.operation > OP_TICK) begin
      end else if (t.operation == OP_ADD) begin
        if (s >= 0) begin
          r = fill(ST_HIT, s);
        end else begin
          f = -1;
          for (int i = 0; i < NSLOT; i++) if (f < 0 && !vld[i]) f = i;
          if (f < 0) begin
            r.status = ST_FULL;
          end else begin
            vld[f] = 1; addrs[f] = a; rest[f] = k;
            owner[f] = t.owner_id; remap[f] = t.remap_addr;
            pol[f] = {t.egress_policy, t.ingress_policy};
            mark[f] = (t.egress_policy[15:8] == encap) ? MARK_ENCAP : 2'd0;
            seen[f] = now_s;
            r = fill(ST_NEW, f);
          end
        end
      end else if (s < 0) begin
        r.status = ST_MISS;
      end else if (t.operation == OP_LOOKUP) begin
        r = fill(ST_HIT, s);
      end else if (t.operation == OP_TOUCH) begin
        freed = 0;
        if (!started) begin
          started = 1; last_sweep = now_s;
        end
        if (now_s - last_sweep > {24'd0, intvl}) begin
          lead = longint'(timeout) - longint'(intvl);
          for (int i = 0; i < NSLOT; i++) begin
            if (vld[i]) begin
              el = now_s - seen[i];
              if (owner[i] != 0 && longint'(el) > lead) mark[i] = MARK_REFRESH;
              if (i != s && el > {16'd0, timeout}) begin
                vld[i] = 0;
                if (freed != FREED_MAX) freed++;
              end
            end
          end
          last_sweep = now_s;
        end
        seen[s] = now_s;
        r = fill(ST_HIT, s);
        r.freed_count = freed;
        freed_total += freed;
      end else begin
        r = fill(ST_HIT, s);
        vld[s] = 0;
      end
      pending.push_back(r);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %0d: %s got %0h want %0h", checked, what, got, want);
      errors++;
    endtask

    task automatic check_result(ftwa_out_t got);
      ftwa_out_t w;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result, status", 32'(got.status), 32'd0);
        return;
      end
      w = pending.pop_front();
      if (got.status !== w.status)
        report_mismatch("status", 32'(got.status), 32'(w.status));
      if (got.slot !== w.slot) report_mismatch("slot", 32'(got.slot), 32'(w.slot));
      if (got.entry_owner !== w.entry_owner)
        report_mismatch("owner", 32'(got.entry_owner), 32'(w.entry_owner));
      if (got.entry_remap !== w.entry_remap)
        report_mismatch("remap", got.entry_remap, w.entry_remap);
      if (got.entry_egress !== w.entry_egress)
        report_mismatch("egress", 32'(got.entry_egress), 32'(w.entry_egress));
      if (got.entry_ingress !== w.entry_ingress)
        report_mismatch("ingress", 32'(got.entry_ingress), 32'(w.entry_ingress));
      if (got.refresh_mark !== w.refresh_mark)
        report_mismatch("mark", 32'(got.refresh_mark), 32'(w.refresh_mark));
      if (got.freed_count !== w.freed_count)
        report_mismatch("freed", 32'(got.freed_count), 32'(w.freed_count));
      checked++;
    endtask
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  ftwa_in_t    in_i = '0;
  logic        done_o;
  ftwa_out_t   res_o;
  logic        cfg_we_i = 0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  flow_scoreboard sb;
  ftwa_in_t key_pool[KEYS];
  int quiet_cycles = 0;
  int sent = 0;

  always #5 clk_i = ~clk_i;

  flow_table_with_aging dut (.*);

  always @(posedge clk_i) begin
    if (start && !busy) sb.note_input(in_i);
    if (done_o) sb.check_result(res_o);
    if ((start && !busy) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("flow_table_with_aging_test: errors");
      $finish;
    end
  end

  // start stays high after a transaction; callers drop it before a gap
  task automatic issue(ftwa_in_t t);
    start <= 1;
    in_i <= t;
    do @(posedge clk_i); while (busy);
    sent++;
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(ftwa_reg_e idx, logic [15:0] v);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.set_reg(idx, v);
    @(posedge clk_i);
  endtask

  function automatic ftwa_in_t rand_item();
    ftwa_in_t t;
    logic [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    t = raw[$bits(ftwa_in_t)-1:0];
    return t;
  endfunction

  function automatic ftwa_in_t pick(ftwa_op_e op);
    ftwa_in_t t;
    t = key_pool[$urandom_range(KEYS - 1)];
    t.operation = op;
    t.owner_id = ($urandom_range(1) != 0) ? 8'($urandom) : 8'd0;
    t.remap_addr = $urandom;
    t.egress_policy = 16'($urandom);
    if ($urandom_range(3) == 0) t.egress_policy[15:8] = sb.encap;
    t.ingress_policy = 16'($urandom);
    return t;
  endfunction

  task automatic random_phase(int n);
    int r, cnt;
    ftwa_op_e op;
    ftwa_in_t t;
    cnt = 0;
    while (cnt < n) begin
      for (int b = $urandom_range(12, 1); b > 0 && cnt < n; b--) begin
        r = $urandom_range(99);
        if (r < 25) op = OP_ADD;
        else if (r < 40) op = OP_LOOKUP;
        else if (r < 62) op = OP_TOUCH;
        else if (r < 72) op = OP_REMOVE;
        else op = OP_TICK;
        t = pick(op);
        if ($urandom_range(39) == 0) begin
          t = rand_item();
          t.operation = 3'($urandom_range(7));
        end
        issue(t);
        cnt++;
      end
      if ($urandom_range(2) != 0) begin
        start <= 0;
        repeat ($urandom_range(30, 1)) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    ftwa_in_t t;
    sb = new();
    for (int i = 0; i < KEYS; i++) begin
      key_pool[i] = rand_item();
      if (i < 4) key_pool[i].ip_ver = (i % 2) ? 4'hF : 4'h0;
    end
    key_pool[0][179:72] = '0;
    key_pool[1][179:72] = '1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;

    // directed: extremes, every code, miss paths, duplicate add, encap mark
    t = key_pool[0]; t.operation = OP_LOOKUP; issue(t);
    t.operation = OP_TOUCH;  issue(t);
    t.operation = OP_REMOVE; issue(t);
    t.operation = OP_ADD; t[71:0] = '0; issue(t);
    t.operation = OP_ADD; issue(t);
    t = key_pool[1]; t.operation = OP_ADD; t[71:0] = '1;
    t.egress_policy[15:8] = ENCAP_CODE_RST; issue(t);
    t.operation = OP_TOUCH;  issue(t);
    t.operation = OP_LOOKUP; issue(t);
    for (int c = 5; c < 8; c++) begin
      t = rand_item(); t.operation = 3'(c); issue(t);
    end
    t = key_pool[0]; t.operation = OP_REMOVE; issue(t);
    t.operation = OP_LOOKUP; issue(t);
    // fill the table to overflow
    for (int i = 2; i < 67; i++) begin
      t = key_pool[i]; t.operation = OP_ADD; issue(t);
    end
    repeat (10) begin
      t.operation = OP_TICK; issue(t);
    end
    t = key_pool[3]; t.operation = OP_TOUCH; issue(t);
    drain();

    random_phase(300);
    drain();
    write_reg(REG_IDLE_TIMEOUT, 16'd1);
    write_reg(REG_CHECK_INTVL, 16'd1);
    write_reg(REG_ENCAP_CODE, 16'd0);
    random_phase(300);
    drain();
    write_reg(REG_IDLE_TIMEOUT, 16'd4);
    write_reg(REG_CHECK_INTVL, 16'd255);
    write_reg(REG_ENCAP_CODE, 16'd255);
    random_phase(250);
    drain();
    write_reg(REG_IDLE_TIMEOUT, 16'hFFFF);
    write_reg(REG_CHECK_INTVL, 16'd2);
    write_reg(REG_ENCAP_CODE, 16'd7);
    random_phase(250);
    drain();
    write_reg(REG_IDLE_TIMEOUT, 16'd12);
    write_reg(REG_CHECK_INTVL, 16'd3);
    write_reg(REG_ENCAP_CODE, 16'd1);
    random_phase(350);
    drain();

    $display("covered %0d transactions, %0d results checked, %0d entries aged out",
             sent, sb.checked, sb.freed_total);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("flow_table_with_aging_test: clean");
    end else begin
      $display("flow_table_with_aging_test: errors");
    end
    $finish;
  end
endmodule

// ----- files.f -----
src/ftwa_pkg.sv
src/ftwa_ram.sv
src/ftwa_front.sv
src/ftwa_back.sv
src/flow_table_with_aging.sv
tb/flow_table_with_aging_test.sv
